// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers on the block clock and active-low reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define ASSERT_CLK(name, prop, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// assertion on clk_i and rst_ni
`define ASSERT_DEF(name, prop) `ASSERT_CLK(name, prop, clk_i, rst_ni)

`endif

// ===== design/tdp_pkg.sv =====
// ---------------------------------------------------------------------------
// tdp_pkg
// types, constants and helpers of the trapezoid drive profile
// ---------------------------------------------------------------------------
package tdp_pkg;

  localparam int unsigned SPEED_LIMIT_DEFAULT = 400;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_SPEED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_SPEED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DISTANCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADING_GAIN  = 3'd4;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  localparam logic [8:0]  CRUISE_RESET = 9'd400;
  localparam logic [8:0]  FLOOR_RESET  = 9'd140;
  localparam logic [5:0]  ACCEL_RESET  = 6'd2;
  localparam logic [15:0] SLOW_RESET   = 16'd1400;
  localparam logic [3:0]  GAIN_RESET   = 4'd5;

  // degrees per full turn, applied to the upper half of the heading
  localparam logic signed [16:0] DEG_FULL = 17'sd360;

  localparam int unsigned DIV_STEPS = 36;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_ANG,
    S_CORR,
    S_DEC,
    S_MA,
    S_MB,
    S_NUM,
    S_DIV,
    S_QUO,
    S_FIN,
    S_OUT
  } tdp_state_e;

  // goal minus travelled, saturated to 25 bits signed
  function automatic logic [24:0] sat_remaining(input logic signed [25:0] v);
    logic [24:0] r;
    if (v > 26'sd16777215) begin
      r = 25'h0FFFFFF;
    end else if (v < -26'sd16777216) begin
      r = 25'h1000000;
    end else begin
      r = v[24:0];
    end
    return r;
  endfunction

  // motor command saturated to +-lim
  function automatic logic [9:0] sat_speed(input logic signed [13:0] v,
                                           input logic signed [13:0] lim);
    logic [9:0] r;
    if (v > lim) begin
      r = lim[9:0];
    end else if (v < -lim) begin
      r = 10'(-lim);
    end else begin
      r = v[9:0];
    end
    return r;
  endfunction

endpackage

// ===== design/trapezoid_drive_profile.sv =====
// ---------------------------------------------------------------------------
// trapezoid_drive_profile
// straight drive speed profile with heading correction
// ---------------------------------------------------------------------------
// One item in, one result out. A start item (tuser 0) loads the target and
// goes straight to S_OUT, as does a tick while idle. A tick during a move
// runs S_ACC to S_DEC, S_FIN and S_OUT; in the slow-down zone, with no
// speed-up and a nonzero slow distance, it adds S_MA to S_QUO, where a
// 36-step restoring divider works out the ramp-down speed; one shared
// 27x17 multiplier serves heading scale, heading correction and ramp
// numerator. The input is ready only in S_IDLE; a result waits in the
// output register as the next item is taken. Done is signalled on tlast.
module trapezoid_drive_profile #(
  parameter int unsigned SPEED_LIMIT = tdp_pkg::SPEED_LIMIT_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tdp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tdp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // target_count, left_delta, heading_raw
  input  logic [tdp_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // mode
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // left_speed, right_speed, remaining, zero pad
  output logic [tdp_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // done_res
  output logic                              m_axis_tlast_o
);
  import tdp_pkg::*;

  localparam logic signed [13:0] LimS = 14'(SPEED_LIMIT);

  tdp_state_e state_q, state_d;

  logic [8:0]  cruise_q, floor_q;
  logic [5:0]  accel_q;
  logic [15:0] slow_q;
  logic [3:0]  gain_q;

  logic [23:0]        goal_q, goal_d;
  logic signed [24:0] trav_q, trav_d;
  logic signed [9:0]  ps_q, ps_d;
  logic               moving_q, moving_d;

  logic signed [15:0] delta_q, delta_d;
  logic signed [15:0] hi_q, hi_d;
  logic signed [25:0] dist_q, dist_d;
  logic signed [12:0] corr_q, corr_d;
  logic signed [43:0] prod_a_q, prod_a_d;
  logic signed [43:0] mul_q;
  logic               neg_q, neg_d;
  logic [35:0]        quo_q, quo_d;
  logic [15:0]        rem_q, rem_d;
  logic [5:0]         cnt_q, cnt_d;

  logic [9:0]  res_l_q, res_l_d, res_r_q, res_r_d;
  logic [24:0] res_rem_q, res_rem_d;
  logic        res_done_q, res_done_d;

  logic        m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;
  logic        m_last_q, m_last_d;

  // shared multiplier
  logic signed [26:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [43:0] mul_p;

  logic signed [25:0] trav_sum, trav_new, dist_new, idle_dist;
  logic signed [8:0]  angle;
  logic signed [11:0] ps_ext, cruise_ext, floor_ext, accel_sum;
  logic signed [25:0] slow_ext;
  logic signed [43:0] num, num_mag;
  logic [16:0]        rem_sh;
  logic               rem_ge;
  logic signed [36:0] quo_s, ns, ps_ext37;
  logic signed [13:0] l_sum, r_sum;
  logic [9:0]         ps_upd;
  logic signed [13:0] ps_cand;
  logic               in_acc, out_free;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;

  assign trav_sum = {trav_q[24], trav_q} + {{10{delta_q[15]}}, delta_q};
  assign trav_new = (trav_sum > 26'sd16777215) ? 26'sd16777215 :
                    (trav_sum < -26'sd16777216) ? -26'sd16777216 : trav_sum;
  assign dist_new  = $signed({2'b00, goal_q}) - trav_new;
  assign idle_dist = $signed({2'b00, goal_q}) - {trav_q[24], trav_q};

  assign angle      = mul_q[24:16];
  assign ps_ext     = {{2{ps_q[9]}}, ps_q};
  assign cruise_ext = $signed({3'b000, cruise_q});
  assign floor_ext  = $signed({3'b000, floor_q});
  assign accel_sum  = ps_ext + $signed({6'b000000, accel_q});
  assign slow_ext   = $signed({10'd0, slow_q});

  assign num     = prod_a_q - mul_q;
  assign num_mag = num[43] ? -num : num;

  assign rem_sh = {rem_q, quo_q[35]};
  assign rem_ge = rem_sh >= {1'b0, slow_q};

  assign quo_s    = $signed({1'b0, quo_q});
  assign ns       = neg_q ? -quo_s : quo_s;
  assign ps_ext37 = {{27{ps_q[9]}}, ps_q};

  assign l_sum = {{4{ps_q[9]}}, ps_q} + {corr_q[12], corr_q};
  assign r_sum = {{4{ps_q[9]}}, ps_q} - {corr_q[12], corr_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_ANG: begin
        mul_a = {{11{hi_q[15]}}, hi_q};
        mul_b = DEG_FULL;
      end
      S_CORR: begin
        mul_a = {{18{angle[8]}}, angle};
        mul_b = $signed({13'd0, gain_q});
      end
      S_MA: begin
        mul_a = $signed({18'd0, cruise_q});
        mul_b = $signed({1'b0, slow_q});
      end
      S_MB: begin
        mul_a = {slow_ext[25], slow_ext} - {dist_q[25], dist_q};
        mul_b = {{5{cruise_ext[11]}}, cruise_ext} - {{5{floor_ext[11]}}, floor_ext};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // speed chosen at the decision step, before saturation
  always_comb begin
    ps_cand = {{4{ps_q[9]}}, ps_q};
    if (ps_ext < cruise_ext && dist_q >= slow_ext) begin
      ps_cand = (accel_sum > cruise_ext) ? {{2{cruise_ext[11]}}, cruise_ext}
                                         : {{2{accel_sum[11]}}, accel_sum};
    end else if (ps_ext < floor_ext) begin
      ps_cand = (accel_sum > floor_ext) ? {{2{floor_ext[11]}}, floor_ext}
                                        : {{2{accel_sum[11]}}, accel_sum};
    end else if (dist_q < slow_ext && slow_q == 16'd0) begin
      if (floor_ext < ps_ext) begin
        ps_cand = {{2{floor_ext[11]}}, floor_ext};
      end
    end
    ps_upd = sat_speed(ps_cand, LimS);
  end

  always_comb begin
    state_d    = state_q;
    goal_d     = goal_q;
    trav_d     = trav_q;
    ps_d       = ps_q;
    moving_d   = moving_q;
    delta_d    = delta_q;
    hi_d       = hi_q;
    dist_d     = dist_q;
    corr_d     = corr_q;
    prod_a_d   = prod_a_q;
    neg_d      = neg_q;
    quo_d      = quo_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    res_l_d    = res_l_q;
    res_r_d    = res_r_q;
    res_rem_d  = res_rem_q;
    res_done_d = res_done_q;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    m_data_d   = m_data_q;
    m_last_d   = m_last_q;
    s_axis_tready_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (in_acc) begin
          if (s_axis_tuser_i == MODE_START) begin
            goal_d     = s_axis_tdata_i[23:0];
            trav_d     = '0;
            ps_d       = sat_speed($signed({8'd0, accel_q}), LimS);
            moving_d   = s_axis_tdata_i[23:0] != 24'd0;
            res_l_d    = '0;
            res_r_d    = '0;
            res_rem_d  = {1'b0, s_axis_tdata_i[23:0]};
            res_done_d = s_axis_tdata_i[23:0] == 24'd0;
            state_d    = S_OUT;
          end else if (!moving_q) begin
            res_l_d    = '0;
            res_r_d    = '0;
            res_rem_d  = sat_remaining(idle_dist);
            res_done_d = 1'b0;
            state_d    = S_OUT;
          end else begin
            delta_d = $signed(s_axis_tdata_i[39:24]);
            hi_d    = $signed(s_axis_tdata_i[71:56]);
            state_d = S_ACC;
          end
        end
      end
      S_ACC: begin
        trav_d  = trav_new[24:0];
        dist_d  = dist_new;
        state_d = S_ANG;
      end
      S_ANG: begin
        state_d = S_CORR;
      end
      S_CORR: begin
        state_d = S_DEC;
      end
      S_DEC: begin
        corr_d = mul_q[12:0];
        if (!(ps_ext < cruise_ext && dist_q >= slow_ext) && !(ps_ext < floor_ext) &&
            dist_q < slow_ext && slow_q != 16'd0) begin
          state_d = S_MA;
        end else begin
          ps_d    = ps_upd;
          state_d = S_FIN;
        end
      end
      S_MA: begin
        state_d = S_MB;
      end
      S_MB: begin
        prod_a_d = mul_q;
        state_d  = S_NUM;
      end
      S_NUM: begin
        neg_d   = num[43];
        quo_d   = num_mag[35:0];
        rem_d   = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = rem_ge ? 16'(rem_sh - {1'b0, slow_q}) : rem_sh[15:0];
        quo_d = {quo_q[34:0], rem_ge};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_QUO;
        end
      end
      S_QUO: begin
        if (ns < ps_ext37) begin
          ps_d = (ns < -$signed(37'(SPEED_LIMIT))) ? 10'(-LimS) : ns[9:0];
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        res_l_d    = sat_speed(l_sum, LimS);
        res_r_d    = sat_speed(r_sum, LimS);
        res_rem_d  = sat_remaining(dist_q);
        res_done_d = dist_q <= 26'sd0;
        moving_d   = !(dist_q <= 26'sd0);
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {3'b000, res_rem_q, res_r_q, res_l_q};
          m_last_d  = res_done_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      goal_q    <= '0;
      trav_q    <= '0;
      ps_q      <= '0;
      moving_q  <= 1'b0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      cruise_q  <= CRUISE_RESET;
      floor_q   <= FLOOR_RESET;
      accel_q   <= ACCEL_RESET;
      slow_q    <= SLOW_RESET;
      gain_q    <= GAIN_RESET;
    end else begin
      state_q   <= state_d;
      goal_q    <= goal_d;
      trav_q    <= trav_d;
      ps_q      <= ps_d;
      moving_q  <= moving_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CRUISE_SPEED:  cruise_q <= cfg_data_i[8:0];
          CFG_FLOOR_SPEED:   floor_q  <= cfg_data_i[8:0];
          CFG_ACCEL_STEP:    accel_q  <= cfg_data_i[5:0];
          CFG_SLOW_DISTANCE: slow_q   <= cfg_data_i;
          CFG_HEADING_GAIN:  gain_q   <= cfg_data_i[3:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q    <= delta_d;
    hi_q       <= hi_d;
    dist_q     <= dist_d;
    corr_q     <= corr_d;
    prod_a_q   <= prod_a_d;
    mul_q      <= mul_p;
    neg_q      <= neg_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    res_l_q    <= res_l_d;
    res_r_q    <= res_r_d;
    res_rem_q  <= res_rem_d;
    res_done_q <= res_done_d;
    m_data_q   <= m_data_d;
    m_last_q   <= m_last_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

`include "assert_macros.svh"

  `ASSERT_DEF(a_start_moves, in_acc && s_axis_tuser_i == MODE_START && s_axis_tdata_i[23:0] != 24'd0 |=> moving_q)
  `ASSERT_DEF(a_out_from_seq, $rose(m_axis_tvalid_o) |-> $past(state_q) == S_OUT)
  `ASSERT_DEF(a_speed_range, ps_ext <= LimS && ps_ext >= -LimS)

endmodule

// ===== sim/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the trapezoid drive profile: stream items in,
// predict motor commands and remaining count, compare each result in order
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tdp_pkg::*;

  localparam longint LIM      = longint'(SPEED_LIMIT_DEFAULT);
  localparam longint TRAV_TOP = 64'sd16777215;
  localparam longint TRAV_BOT = -64'sd16777216;

  typedef struct {
    logic [9:0]  left_cmd;
    logic [9:0]  right_cmd;
    logic [24:0] rem;
    logic        done;
  } motor_cmd_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;
  logic                    s_axis_tvalid_i;
  logic                    s_axis_tready_o;
  logic [IN_DATA_W-1:0]    s_axis_tdata_i;
  logic                    s_axis_tuser_i;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i;
  logic [OUT_DATA_W-1:0]   m_axis_tdata_o;
  logic                    m_axis_tlast_o;

  trapezoid_drive_profile DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // profile state mirrored by the bench
  logic [8:0]  cruise_r;
  logic [8:0]  floor_r;
  logic [5:0]  accel_r;
  logic [15:0] slow_r;
  logic [3:0]  gain_r;
  longint      trav;
  longint      spd;
  longint      goal_cnt;
  bit          in_motion;

  motor_cmd_t  motor_cmd_q[$];

  int  errors;
  int  items_sent;
  int  results_seen;
  int  moves_finished;
  int  ramp_down_ticks;
  int  reg_writes;
  int  burst_left;
  bit  sender_gaps;
  int  stall_style;
  int  hold_left;
  logic [15:0] stall_pat;

  always #10 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_item(input logic [23:0] tgt,
                                                     input logic [15:0] dl,
                                                     input logic [31:0] hd);
    return {hd, dl, tgt};
  endfunction

  function automatic void profile_predict(input logic mode, input logic [IN_DATA_W-1:0] data);
    motor_cmd_t c;
    longint dlt, ang, d, ns, corr, cr, fl, sl;
    c.left_cmd  = '0;
    c.right_cmd = '0;
    c.done      = 1'b0;
    if (mode == MODE_START) begin
      goal_cnt  = longint'(data[23:0]);
      trav      = 0;
      spd       = clip(longint'(accel_r), -LIM, LIM);
      in_motion = goal_cnt != 0;
      c.done    = !in_motion;
    end else if (in_motion) begin
      dlt  = longint'($signed(data[39:24]));
      cr   = longint'(cruise_r);
      fl   = longint'(floor_r);
      sl   = longint'(slow_r);
      trav = clip(trav + dlt, TRAV_BOT, TRAV_TOP);
      // heading: upper half times 360, then upper half again, both floored
      ang  = ((longint'($signed(data[71:40])) >>> 16) * 360) >>> 16;
      d    = goal_cnt - trav;
      if (spd < cr && d >= sl) begin
        spd = spd + longint'(accel_r);
        if (spd > cr) spd = cr;
      end else if (spd < fl) begin
        spd = spd + longint'(accel_r);
        if (spd > fl) spd = fl;
      end else if (d < sl) begin
        ramp_down_ticks++;
        if (sl == 0) ns = fl;
        else ns = (cr * sl - (sl - d) * (cr - fl)) / sl;
        if (ns < spd) spd = ns;
      end
      spd  = clip(spd, -LIM, LIM);
      corr = ang * longint'(gain_r);
      c.left_cmd  = 10'(clip(spd + corr, -LIM, LIM));
      c.right_cmd = 10'(clip(spd - corr, -LIM, LIM));
      if (trav >= goal_cnt) begin
        in_motion = 1'b0;
        c.done    = 1'b1;
        moves_finished++;
      end
    end
    c.rem = 25'(clip(goal_cnt - trav, TRAV_BOT, TRAV_TOP));
    motor_cmd_q.push_back(c);
  endfunction

  task automatic send_item(input logic mode, input logic [IN_DATA_W-1:0] data);
    int gap;
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = data;
    s_axis_tuser_i  = mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    profile_predict(mode, data);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = sender_gaps ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic send_tick(input logic [15:0] dl, input logic [31:0] hd);
    send_item(MODE_TICK, pack_item(24'($urandom), dl, hd));
  endtask

  task automatic send_start(input logic [23:0] tgt);
    send_item(MODE_START, pack_item(tgt, 16'($urandom), $urandom));
  endtask

  // wait until every result is in, then let the sequencer settle
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (motor_cmd_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    reg_writes++;
    case (idx)
      CFG_CRUISE_SPEED:  cruise_r = val[8:0];
      CFG_FLOOR_SPEED:   floor_r  = val[8:0];
      CFG_ACCEL_STEP:    accel_r  = val[5:0];
      CFG_SLOW_DISTANCE: slow_r   = val;
      CFG_HEADING_GAIN:  gain_r   = val[3:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] cr, input logic [15:0] fl, input logic [15:0] ac,
                           input logic [15:0] sl, input logic [15:0] gn);
    write_reg(CFG_CRUISE_SPEED, cr);
    write_reg(CFG_FLOOR_SPEED, fl);
    write_reg(CFG_ACCEL_STEP, ac);
    write_reg(CFG_SLOW_DISTANCE, sl);
    write_reg(CFG_HEADING_GAIN, gn);
  endtask

  // heading within about +-30 degrees
  function automatic logic [31:0] small_heading();
    return 32'($urandom_range(0, 716000000) - 358000000);
  endfunction

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready_i = 1'b0;
      hold_left--;
    end else begin
      case (stall_style)
        0: m_axis_tready_i = 1'b1;
        1: m_axis_tready_i = ($urandom_range(0, 2) != 0);
        default: begin
          stall_pat = {stall_pat[14:0], stall_pat[15]};
          m_axis_tready_i = stall_pat[0];
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    motor_cmd_t exp_c;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      if (motor_cmd_q.size() == 0) begin
        $error("result with no item pending: tdata %h tlast %b", m_axis_tdata_o, m_axis_tlast_o);
        errors++;
      end else begin
        exp_c = motor_cmd_q.pop_front();
        if (m_axis_tdata_o[9:0] !== exp_c.left_cmd) begin
          $error("left_speed expected %0d actual %0d", $signed(exp_c.left_cmd),
                 $signed(m_axis_tdata_o[9:0]));
          errors++;
        end
        if (m_axis_tdata_o[19:10] !== exp_c.right_cmd) begin
          $error("right_speed expected %0d actual %0d", $signed(exp_c.right_cmd),
                 $signed(m_axis_tdata_o[19:10]));
          errors++;
        end
        if (m_axis_tdata_o[44:20] !== exp_c.rem) begin
          $error("remaining expected %0d actual %0d", $signed(exp_c.rem),
                 $signed(m_axis_tdata_o[44:20]));
          errors++;
        end
        if (m_axis_tlast_o !== exp_c.done) begin
          $error("done_res expected %b actual %b", exp_c.done, m_axis_tlast_o);
          errors++;
        end
      end
    end
  end

  task automatic test_idle_and_start();
    stall_style = 0;
    sender_gaps = 1'b0;
    send_tick(16'h8000, 32'h8000_0000);
    send_start(24'd0);
    send_start(24'hFF_FFFF);
    send_tick(16'h7FFF, 32'h7FFF_FFFF);
    send_tick(16'h8000, 32'h8000_0000);
    send_tick(16'h0000, 32'hFFFF_FFFF);
    send_tick(16'h0001, 32'h0000_0000);
    send_start(24'd300);
    send_tick(16'd100, small_heading());
    send_tick(16'd100, small_heading());
    send_tick(16'h7FFF, small_heading());
    send_tick(16'd5, 32'h4000_0000);
  endtask

  task automatic test_register_extremes();
    settle();
    stall_style = 2;
    write_all(16'hFFFF, 16'h0000, 16'd63, 16'hFFFF, 16'd15);
    send_start(24'd20000);
    send_tick(16'd1000, 32'h7FFF_FFFF);
    send_tick(16'd1000, 32'h8000_0000);
    send_tick(16'd1000, small_heading());
    settle();
    write_all(16'd0, 16'd400, 16'd0, 16'd0, 16'd0);
    send_start(24'd50);
    send_tick(16'd10, small_heading());
    send_tick(16'h7FFF, small_heading());
    settle();
    write_all(16'd400, 16'd140, 16'd1, 16'd0, 16'd15);
    send_start(24'd40);
    send_tick(16'd20, small_heading());
    send_tick(16'd20, small_heading());
  endtask

  task automatic test_travel_saturation();
    settle();
    stall_style = 1;
    sender_gaps = 1'b1;
    write_all(16'd400, 16'd140, 16'd2, 16'd1400, 16'd5);
    send_start(24'hFF_FFFF);
    send_tick(16'hFFFF, small_heading());
    send_tick(16'h8000, $urandom);
    send_tick(16'h8000, small_heading());
    send_tick(16'h7FFF, $urandom);
    send_start(24'd65000);
    while (in_motion) send_tick(16'h7FFF, small_heading());
  endtask

  task automatic test_output_backpressure();
    int n;
    settle();
    stall_style = 0;
    sender_gaps = 1'b0;
    send_start(24'd60000);
    hold_left = 400;
    for (n = 0; n < 30; n++) send_tick(16'd100, small_heading());
  endtask

  task automatic test_random_moves();
    int moves, ticks, budget;
    logic [15:0] slow_v;
    moves  = 0;
    budget = items_sent + 440;
    while (items_sent < budget) begin
      if (moves % 4 == 0) begin
        settle();
        stall_style = $urandom_range(0, 2);
        sender_gaps = $urandom_range(0, 1);
        stall_pat   = 16'($urandom) | 16'h0001;
        case ($urandom_range(0, 7))
          0: slow_v = 16'd0;
          1: slow_v = 16'($urandom);
          default: slow_v = 16'($urandom_range(1, 3000));
        endcase
        write_all(($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400)),
                  ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400)),
                  ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 63)),
                  slow_v, 16'($urandom));
      end
      moves++;
      send_start(($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 6000)));
      ticks = 0;
      while (in_motion && ticks < 60 && items_sent < budget) begin
        ticks++;
        case ($urandom_range(0, 19))
          0: send_item(1'($urandom), pack_item(24'($urandom), 16'($urandom), $urandom));
          1, 2: send_tick(16'(-$urandom_range(1, 200)), small_heading());
          3: send_tick(16'($urandom_range(20, 300)), $urandom);
          default: send_tick(16'($urandom_range(20, 300)), small_heading());
        endcase
      end
      if ($urandom_range(0, 3) == 0)
        send_tick(16'($urandom), $urandom);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = 1'b0;
    m_axis_tready_i = 1'b1;
    cruise_r = CRUISE_RESET;
    floor_r = FLOOR_RESET;
    accel_r = ACCEL_RESET;
    slow_r = SLOW_RESET;
    gain_r = GAIN_RESET;
    trav = 0;
    spd = 0;
    goal_cnt = 0;
    in_motion = 1'b0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    moves_finished = 0;
    ramp_down_ticks = 0;
    reg_writes = 0;
    burst_left = 0;
    sender_gaps = 1'b0;
    stall_style = 0;
    hold_left = 0;
    stall_pat = 16'hB5A3;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_and_start();
    test_register_extremes();
    test_travel_saturation();
    test_output_backpressure();
    test_random_moves();
    settle();

    $display("run covered %0d items and %0d results, %0d moves finished", items_sent,
             results_seen, moves_finished);
    $display("%0d ticks in the ramp-down zone, %0d register writes", ramp_down_ticks,
             reg_writes);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
